@@ rtl/fleuf_pkg.sv @@
// ----------------------------------------------------------------------------
// fleuf_pkg: shared types and constants of the upwind flux stage
// Field widths, register indexes, the queue entry format, and the
// fixed-point helpers used by the back end.
// ----------------------------------------------------------------------------
package fleuf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;
    localparam int GW        = 19;
    localparam int TW        = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TSTEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd2;

    localparam logic [GW-1:0] GAMMA_RST = 19'd26214;
    localparam logic [TW-1:0] TSTEP_RST = 31'd65;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // One cell as held in the window
    typedef struct packed {
        logic signed [QW-1:0] rho;
        logic signed [QW-1:0] u;
        logic signed [QW-1:0] v;
        logic signed [QW-1:0] p;
    } cell_t;

    // One job handed from front to back: left, middle, right cells
    typedef struct packed {
        cell_t         left;
        cell_t         mid;
        cell_t         right;
        logic [TW-1:0] spacing;
        logic          line_end;
    } job_t;

    // Saturate a 66-bit signed value to Q range
    function automatic logic signed [QW-1:0] sat66(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'(signed'(Q_MAX));
            lo = 66'(signed'(Q_MIN));
            if (x > hi)
                sat66 = Q_MAX;
            else if (x < lo)
                sat66 = Q_MIN;
            else
                sat66 = x[QW-1:0];
        end
    endfunction

    // Q multiply of a registered product: floor shift then saturate
    function automatic logic signed [QW-1:0] qscale(input logic signed [65:0] prod);
        logic signed [65:0] sh;
        begin
            sh = prod >>> FRAC_BITS;
            qscale = sat66(sh);
        end
    endfunction

    function automatic logic signed [QW-1:0] qadd(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [65:0] s;
        begin
            s = 66'(a) + 66'(b);
            qadd = sat66(s);
        end
    endfunction

    function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [65:0] s;
        begin
            s = 66'(a) - 66'(b);
            qsub = sat66(s);
        end
    endfunction

endpackage

@@ rtl/fleuf_div.sv @@
// ----------------------------------------------------------------------------
// fleuf_div: iterative signed fixed-point divider
// Computes sat((a << FRAC_BITS) / b), truncated toward zero, one quotient
// bit per cycle. A zero divisor gives the saturated sign of a.
// ----------------------------------------------------------------------------
module fleuf_div
    import fleuf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [QW-1:0] num,
    input  logic signed [QW-1:0] den,
    output logic                 done,
    output logic signed [QW-1:0] quo
);

    localparam int NW = QW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg,   n_next;
    logic [QW-1:0] d_reg,   d_next;
    logic [NW-1:0] q_reg,   q_next;
    logic [QW:0]   r_reg,   r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic signed [QW-1:0] quo_reg, quo_next;

    logic [QW:0]   trial;
    logic [QW:0]   rsh;
    logic [NW:0]   qmag;

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rsh       = {r_reg[QW-1:0], n_reg[NW-1]};
        trial     = rsh - {1'b0, d_reg};
        qmag      = '0;
        if (start)
        begin
            if (den == '0)
            begin
                done_next = 1'b1;
                quo_next  = (num == '0) ? '0 : (num[QW-1] ? Q_MIN : Q_MAX);
            end
            else
            begin
                n_next    = {(num[QW-1] ? QW'(-num) : QW'(num)), {FRAC_BITS{1'b0}}};
                d_next    = den[QW-1] ? QW'(-den) : QW'(den);
                neg_next  = num[QW-1] ^ den[QW-1];
                q_next    = '0;
                r_next    = '0;
                cnt_next  = CW'(NW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[NW-2:0], 1'b0};
            if (!trial[QW])
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = rsh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                qmag      = {1'b0, q_next};
                if (neg_reg)
                    quo_next = (qmag > (NW+1)'(33'h8000_0000)) ? Q_MIN
                             : QW'(-qmag);
                else
                    quo_next = (qmag > (NW+1)'(32'h7FFF_FFFF)) ? Q_MAX : qmag[QW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/fleuf_front.sv @@
// ----------------------------------------------------------------------------
// fleuf_front: cell window and job issue
// Shift cells into the three-cell window and push a job for each middle
// cell that has both neighbors; empty the window on the line end.
// ----------------------------------------------------------------------------
module fleuf_front
    import fleuf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  logic signed [QW-1:0] density,
    input  logic signed [QW-1:0] x_velocity,
    input  logic signed [QW-1:0] y_velocity,
    input  logic signed [QW-1:0] pressure,
    input  logic [TW-1:0]        cell_spacing,
    input  logic                 line_end,
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);

    cell_t         left_reg,  left_next;
    cell_t         mid_reg,   mid_next;
    logic [TW-1:0] sp_reg,    sp_next;
    logic [1:0]    seen_reg,  seen_next;
    logic          jv_reg,    jv_next;
    job_t          job_reg,   job_next;
    cell_t         arrive;
    logic          take;

    // Single-entry queue slot; a cell is taken only when the slot can hold
    // any job it produces.
    assign ready = !jv_reg || job_ready;
    assign take  = valid && ready;

    always_comb
    begin
        arrive    = '{rho: density, u: x_velocity, v: y_velocity, p: pressure};
        left_next = left_reg;
        mid_next  = mid_reg;
        sp_next   = sp_reg;
        seen_next = seen_reg;
        job_next  = job_reg;
        jv_next   = jv_reg && !job_ready;
        if (take)
        begin
            if (seen_reg == 2'd2)
            begin
                jv_next  = 1'b1;
                job_next = '{left: left_reg, mid: mid_reg, right: arrive,
                             spacing: sp_reg, line_end: line_end};
            end
            left_next = mid_reg;
            mid_next  = arrive;
            sp_next   = cell_spacing;
            if (line_end)
                seen_next = 2'd0;
            else if (seen_reg != 2'd2)
                seen_next = seen_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 2'd0;
            jv_reg   <= 1'b0;
            left_reg <= '0;
            mid_reg  <= '0;
            sp_reg   <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            jv_reg   <= jv_next;
            left_reg <= left_next;
            mid_reg  <= mid_next;
            sp_reg   <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_valid = jv_reg;
    assign job       = job_reg;

endmodule

@@ rtl/fleuf_back.sv @@
// ----------------------------------------------------------------------------
// fleuf_back: flux and update sequencer
// Walk one job through a microcoded sequence around a shared multiplier
// and the iterative divider, then present the updated cell.
// ----------------------------------------------------------------------------
module fleuf_back
    import fleuf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  job_t                 job,
    input  logic [GW-1:0]        gamma_m1,
    input  logic [TW-1:0]        tstep,
    input  logic                 axis,
    output logic                 valid,
    input  logic                 ready,
    output logic [TW-1:0]        new_density,
    output logic signed [QW-1:0] new_x_velocity,
    output logic signed [QW-1:0] new_y_velocity,
    output logic [TW-1:0]        new_pressure,
    output logic                 result_line_end
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    // Register file slots
    typedef enum logic [4:0] {
        R_ZERO, R_RHO, R_U, R_V, R_P, R_N, R_M, R_E, R_K, R_T,
        R_FM0, R_FM1, R_FM2, R_FM3, R_FP0, R_FP1, R_FP2, R_FP3,
        R_RAT, R_MX, R_MY, R_EN, R_RN, R_UN, R_VN, R_A, R_B, R_GM, R_TS, R_SP
    } slot_t;

    localparam int NSLOT = 30;
    localparam int PW    = 6;

    // Micro-op kinds
    typedef enum logic [2:0] {
        OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_HALF, OP_LOAD, OP_FLOOR, OP_END
    } op_t;

    typedef struct packed {
        op_t   op;
        slot_t d;
        slot_t a;
        slot_t b;
    } uop_t;

    state_t              state_reg, state_next;
    logic [PW-1:0]       pc_reg,    pc_next;
    logic signed [QW-1:0] rf_reg [NSLOT];
    logic signed [65:0]  prod_reg;
    logic [1:0]          face_reg,  face_next;
    logic                skip_reg,  skip_next;
    job_t                job_reg;
    logic                ov_reg,    ov_next;
    logic                div_start;
    logic                div_done;
    logic signed [QW-1:0] div_q;
    uop_t                uop;
    logic signed [QW-1:0] ra, rb, wval;
    logic                we;
    cell_t               sel;
    logic signed [QW-1:0] nsum_a, nsum_b;
    logic signed [QW:0]  nsum;

    // Program: face flux (entry 0..), then update (entry UPD)
    localparam logic [PW-1:0] UPD = 6'd12;

    function automatic uop_t prog(input logic [PW-1:0] pc);
        case (pc)
            // flux of selected cell; N,RHO,U,V,P loaded on entry
            6'd0:  prog = '{OP_MUL, R_M,  R_RHO, R_N};
            6'd1:  prog = '{OP_MUL, R_A,  R_M,   R_U};
            6'd2:  prog = '{OP_MUL, R_B,  R_M,   R_V};
            6'd3:  prog = '{OP_MUL, R_T,  R_U,   R_U};
            6'd4:  prog = '{OP_MUL, R_K,  R_V,   R_V};
            6'd5:  prog = '{OP_ADD, R_T,  R_T,   R_K};
            6'd6:  prog = '{OP_MUL, R_K,  R_RHO, R_T};
            6'd7:  prog = '{OP_HALF,R_K,  R_K,   R_ZERO};
            6'd8:  prog = '{OP_DIV, R_E,  R_P,   R_GM};
            6'd9:  prog = '{OP_ADD, R_E,  R_E,   R_K};
            6'd10: prog = '{OP_MUL, R_E,  R_N,   R_E};
            6'd11: prog = '{OP_END, R_ZERO, R_ZERO, R_ZERO};
            // update of middle cell; RHO,U,V,P hold the middle cell
            6'd12: prog = '{OP_DIV, R_RAT, R_TS, R_SP};
            6'd13: prog = '{OP_SUB, R_T,  R_FP0, R_FM0};
            6'd14: prog = '{OP_MUL, R_T,  R_RAT, R_T};
            6'd15: prog = '{OP_SUB, R_RN, R_RHO, R_T};
            6'd16: prog = '{OP_FLOOR,R_RN, R_RN, R_ZERO};
            6'd17: prog = '{OP_MUL, R_MX, R_RHO, R_U};
            6'd18: prog = '{OP_SUB, R_T,  R_FP1, R_FM1};
            6'd19: prog = '{OP_MUL, R_T,  R_RAT, R_T};
            6'd20: prog = '{OP_SUB, R_MX, R_MX,  R_T};
            6'd21: prog = '{OP_MUL, R_MY, R_RHO, R_V};
            6'd22: prog = '{OP_SUB, R_T,  R_FP2, R_FM2};
            6'd23: prog = '{OP_MUL, R_T,  R_RAT, R_T};
            6'd24: prog = '{OP_SUB, R_MY, R_MY,  R_T};
            6'd25: prog = '{OP_MUL, R_T,  R_U,   R_U};
            6'd26: prog = '{OP_MUL, R_K,  R_V,   R_V};
            6'd27: prog = '{OP_ADD, R_T,  R_T,   R_K};
            6'd28: prog = '{OP_MUL, R_K,  R_RHO, R_T};
            6'd29: prog = '{OP_HALF,R_K,  R_K,   R_ZERO};
            6'd30: prog = '{OP_DIV, R_EN, R_P,   R_GM};
            6'd31: prog = '{OP_ADD, R_EN, R_EN,  R_K};
            6'd32: prog = '{OP_SUB, R_T,  R_FP3, R_FM3};
            6'd33: prog = '{OP_MUL, R_T,  R_RAT, R_T};
            6'd34: prog = '{OP_SUB, R_EN, R_EN,  R_T};
            6'd35: prog = '{OP_DIV, R_UN, R_MX,  R_RN};
            6'd36: prog = '{OP_DIV, R_VN, R_MY,  R_RN};
            6'd37: prog = '{OP_MUL, R_T,  R_UN,  R_UN};
            6'd38: prog = '{OP_MUL, R_K,  R_VN,  R_VN};
            6'd39: prog = '{OP_ADD, R_T,  R_T,   R_K};
            6'd40: prog = '{OP_MUL, R_K,  R_RN,  R_T};
            6'd41: prog = '{OP_HALF,R_K,  R_K,   R_ZERO};
            6'd42: prog = '{OP_SUB, R_T,  R_EN,  R_K};
            6'd43: prog = '{OP_MUL, R_A,  R_GM,  R_T};
            6'd44: prog = '{OP_FLOOR,R_A, R_A,   R_ZERO};
            6'd45: prog = '{OP_END, R_ZERO, R_ZERO, R_ZERO};
            default: prog = '{OP_END, R_ZERO, R_ZERO, R_ZERO};
        endcase
    endfunction

    fleuf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ra),
        .den   (rb),
        .done  (div_done),
        .quo   (div_q)
    );

    assign uop = prog(pc_reg);
    assign ra  = rf_reg[uop.a];
    assign rb  = rf_reg[uop.b];

    // face_reg: 0 = left face, 1 = right face, 2 = update
    always_comb
    begin
        if (face_reg == 2'd0)
        begin
            nsum_a = axis ? job_reg.left.v : job_reg.left.u;
            nsum_b = axis ? job_reg.mid.v  : job_reg.mid.u;
            sel    = (nsum_a + nsum_b > 0 && !nsum[QW]) || (!nsum[QW] && nsum != '0)
                   ? job_reg.left : job_reg.mid;
        end
        else
        begin
            nsum_a = axis ? job_reg.mid.v   : job_reg.mid.u;
            nsum_b = axis ? job_reg.right.v : job_reg.right.u;
            sel    = (!nsum[QW] && nsum != '0) ? job_reg.mid : job_reg.right;
        end
    end
    assign nsum = (QW+1)'(nsum_a) + (QW+1)'(nsum_b);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        face_next  = face_reg;
        skip_next  = skip_reg;
        ov_next    = ov_reg && !ready;
        div_start  = 1'b0;
        we         = 1'b0;
        wval       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_MUL;
                    face_next  = 2'd0;
                    pc_next    = '0;
                end
            end
            S_MUL:
            begin
                // first cycle of a face: decide and load operands
                if (face_reg != 2'd2 && pc_reg == '0 && !skip_reg)
                begin
                    skip_next = 1'b1;
                    if (nsum == '0)
                        pc_next = 6'd11;
                end
                else
                begin
                    case (uop.op)
                        OP_MUL:
                        begin
                            state_next = S_WAIT;
                        end
                        OP_DIV:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        OP_ADD:
                        begin
                            we      = 1'b1;
                            wval    = qadd(ra, rb);
                            pc_next = pc_reg + 1'b1;
                        end
                        OP_SUB:
                        begin
                            we      = 1'b1;
                            wval    = qsub(ra, rb);
                            pc_next = pc_reg + 1'b1;
                        end
                        OP_HALF:
                        begin
                            we      = 1'b1;
                            wval    = ra >>> 1;
                            pc_next = pc_reg + 1'b1;
                        end
                        OP_FLOOR:
                        begin
                            we      = 1'b1;
                            wval    = (ra < 1) ? QW'(1) : ra;
                            pc_next = pc_reg + 1'b1;
                        end
                        OP_END:
                        begin
                            skip_next = 1'b0;
                            if (face_reg == 2'd2)
                            begin
                                if (!ov_reg || ready)
                                begin
                                    ov_next    = 1'b1;
                                    state_next = S_IDLE;
                                end
                            end
                            else
                            begin
                                face_next = face_reg + 2'd1;
                                pc_next   = (face_reg == 2'd1) ? UPD : '0;
                            end
                        end
                        default:
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                we         = 1'b1;
                wval       = qscale(prod_reg);
                pc_next    = pc_reg + 1'b1;
                state_next = S_MUL;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    we         = 1'b1;
                    wval       = div_q;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign job_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            face_reg  <= 2'd0;
            skip_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            face_reg  <= face_next;
            skip_reg  <= skip_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(ra) * 66'(rb);
        if (state_reg == S_IDLE && job_valid)
            job_reg <= job;
        rf_reg[R_ZERO] <= '0;
        rf_reg[R_GM]   <= QW'(gamma_m1);
        rf_reg[R_TS]   <= QW'(tstep);
        rf_reg[R_SP]   <= QW'(job_reg.spacing);
        // entering a face: clear its fluxes and load the upwind cell
        if (state_reg == S_MUL && face_reg != 2'd2 && pc_reg == '0 && !skip_reg)
        begin
            rf_reg[R_RHO] <= sel.rho;
            rf_reg[R_U]   <= sel.u;
            rf_reg[R_V]   <= sel.v;
            rf_reg[R_P]   <= sel.p;
            rf_reg[R_N]   <= axis ? sel.v : sel.u;
            rf_reg[R_M]   <= '0;
            rf_reg[R_A]   <= '0;
            rf_reg[R_B]   <= '0;
            rf_reg[R_E]   <= '0;
        end
        else if (we)
            rf_reg[uop.d] <= wval;
        // leaving a face: file its fluxes; entering update: load middle
        if (state_reg == S_MUL && uop.op == OP_END && face_reg != 2'd2)
        begin
            if (face_reg == 2'd0)
            begin
                rf_reg[R_FM0] <= rf_reg[R_M];
                rf_reg[R_FM1] <= rf_reg[R_A];
                rf_reg[R_FM2] <= rf_reg[R_B];
                rf_reg[R_FM3] <= rf_reg[R_E];
            end
            else
            begin
                rf_reg[R_FP0] <= rf_reg[R_M];
                rf_reg[R_FP1] <= rf_reg[R_A];
                rf_reg[R_FP2] <= rf_reg[R_B];
                rf_reg[R_FP3] <= rf_reg[R_E];
                rf_reg[R_RHO] <= job_reg.mid.rho;
                rf_reg[R_U]   <= job_reg.mid.u;
                rf_reg[R_V]   <= job_reg.mid.v;
                rf_reg[R_P]   <= job_reg.mid.p;
            end
        end
        if (state_reg == S_MUL && uop.op == OP_END && face_reg == 2'd2
            && (!ov_reg || ready))
        begin
            new_density     <= rf_reg[R_RN][TW-1:0];
            new_x_velocity  <= rf_reg[R_UN];
            new_y_velocity  <= rf_reg[R_VN];
            new_pressure    <= rf_reg[R_A][TW-1:0];
            result_line_end <= job_reg.line_end;
        end
    end

    assign valid = ov_reg;

endmodule

@@ rtl/flic_euler_upwind_flux_stage.sv @@
// ----------------------------------------------------------------------------
// flic_euler_upwind_flux_stage: FLIC Euler-stage upwind flux update
// Top level: configuration registers, window front end, job slot and
// the flux/update sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Stream the cells of one grid line on the valid/ready input channel, the
//   last one flagged with line_end. Each transaction after the first two of
//   a line yields one result transaction for the previous (middle) cell on
//   the valid/ready output channel; line_end empties the window, so the
//   first and last cells of a line act only as neighbors.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered and
//   must only happen while the block is idle.
// Timing:
//   The front end takes a cell and parks a job in a one-entry slot. The
//   back end runs a microcoded sequence around one multiplier and one
//   radix-2 divider (four to six divisions per cell) and takes a new job
//   only once the previous result is registered; that sequencer sets the
//   rate.
// Reset:
//   Registers return to gamma 0.4, time step 65 LSB, x sweep; window empty.
// Stall:
//   A held result blocks the sequencer at its end; the front end keeps
//   taking cells until its job slot is full.
// ----------------------------------------------------------------------------
module flic_euler_upwind_flux_stage
    import fleuf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TW-1:0]        cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [QW-1:0] density,
    input  logic signed [QW-1:0] x_velocity,
    input  logic signed [QW-1:0] y_velocity,
    input  logic signed [QW-1:0] pressure,
    input  logic [TW-1:0]        cell_spacing,
    input  logic                 line_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TW-1:0]        new_density,
    output logic signed [QW-1:0] new_x_velocity,
    output logic signed [QW-1:0] new_y_velocity,
    output logic [TW-1:0]        new_pressure,
    output logic                 result_line_end
);

    logic [GW-1:0] gamma_reg;
    logic [TW-1:0] tstep_reg;
    logic          axis_reg;
    logic          job_valid;
    logic          job_ready;
    job_t          job;

    // Hold configuration; writes to unused indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RST;
            tstep_reg <= TSTEP_RST;
            axis_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAMMA: gamma_reg <= cfg_data[GW-1:0];
                REG_TSTEP: tstep_reg <= cfg_data;
                REG_AXIS:  axis_reg  <= cfg_data[0];
                default:   axis_reg  <= axis_reg;
            endcase
        end
    end

    fleuf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (in_valid),
        .ready        (in_ready),
        .density      (density),
        .x_velocity   (x_velocity),
        .y_velocity   (y_velocity),
        .pressure     (pressure),
        .cell_spacing (cell_spacing),
        .line_end     (line_end),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    fleuf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job_ready       (job_ready),
        .job             (job),
        .gamma_m1        (gamma_reg),
        .tstep           (tstep_reg),
        .axis            (axis_reg),
        .valid           (out_valid),
        .ready           (out_ready),
        .new_density     (new_density),
        .new_x_velocity  (new_x_velocity),
        .new_y_velocity  (new_y_velocity),
        .new_pressure    (new_pressure),
        .result_line_end (result_line_end)
    );

endmodule

@@ test/tb_flic_euler_upwind_flux_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flic_euler_upwind_flux_stage: self-checking bench of the upwind flux stage
// Streams grid lines through the block under several register settings and
// handshake pressures. A bit-exact predictor of the window and the flux
// update builds the expected cell updates, and a monitor compares every
// result transaction with them in order.
// ----------------------------------------------------------------------------
module tb_flic_euler_upwind_flux_stage;
    import fleuf_pkg::*;

    localparam longint QHI = 64'sd2147483647;
    localparam longint QLO = -64'sd2147483648;

    // One cell as offered on the input channel
    typedef struct {
        logic signed [QW-1:0] rho;
        logic signed [QW-1:0] u;
        logic signed [QW-1:0] v;
        logic signed [QW-1:0] p;
        logic [TW-1:0]        spacing;
        logic                 last;
    } cell_in_t;

    // One updated middle cell
    typedef struct {
        logic [TW-1:0]        rho;
        logic signed [QW-1:0] u;
        logic signed [QW-1:0] v;
        logic [TW-1:0]        p;
        logic                 last;
    } update_t;

    typedef struct packed {
        longint mass;
        longint mom_x;
        longint mom_y;
        longint nrg;
    } flux_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TW-1:0]        cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [QW-1:0] density;
    logic signed [QW-1:0] x_velocity;
    logic signed [QW-1:0] y_velocity;
    logic signed [QW-1:0] pressure;
    logic [TW-1:0]        cell_spacing;
    logic                 line_end;
    logic                 out_valid;
    logic                 out_ready;
    logic [TW-1:0]        new_density;
    logic signed [QW-1:0] new_x_velocity;
    logic signed [QW-1:0] new_y_velocity;
    logic [TW-1:0]        new_pressure;
    logic                 result_line_end;

    // Predictor copy of the registers and the cell window
    logic [GW-1:0] gamma_m1;
    logic [TW-1:0] tstep;
    logic          axis_y;
    longint        win_rho [2];
    longint        win_u   [2];
    longint        win_v   [2];
    longint        win_p   [2];
    longint        mid_spacing;
    int            held_cells;

    update_t expected_updates[$];

    int error_count;
    int cells_sent;
    int updates_checked;
    int send_idle_pct;
    int recv_stall_pct;

    flic_euler_upwind_flux_stage dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .density         (density),
        .x_velocity      (x_velocity),
        .y_velocity      (y_velocity),
        .pressure        (pressure),
        .cell_spacing    (cell_spacing),
        .line_end        (line_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .new_density     (new_density),
        .new_x_velocity  (new_x_velocity),
        .new_y_velocity  (new_y_velocity),
        .new_pressure    (new_pressure),
        .result_line_end (result_line_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------
    function automatic longint clip(input longint x);
        if (x > QHI)
            return QHI;
        if (x < QLO)
            return QLO;
        return x;
    endfunction

    // Exact product, floor shift, saturate
    function automatic longint qmul(input longint a, input longint b);
        return clip((a * b) >>> FRAC_BITS);
    endfunction

    // Truncating quotient; a zero divisor saturates with the numerator's sign
    function automatic longint qdiv(input longint a, input longint b);
        if (b == 0)
            return (a > 0) ? QHI : ((a < 0) ? QLO : 0);
        return clip((a * (64'sd1 <<< FRAC_BITS)) / b);
    endfunction

    function automatic longint kinetic(input longint rho, input longint u, input longint v);
        longint s;
        s = clip(qmul(u, u) + qmul(v, v));
        return qmul(rho, s) >>> 1;
    endfunction

    function automatic longint total_energy(input longint rho, input longint u,
                                            input longint v, input longint p);
        return clip(qdiv(p, longint'(gamma_m1)) + kinetic(rho, u, v));
    endfunction

    function automatic flux_t upwind_flux(input longint rho, input longint u,
                                          input longint v, input longint p);
        flux_t  f;
        longint n;
        n = axis_y ? v : u;
        f.mass  = qmul(rho, n);
        f.mom_x = qmul(f.mass, u);
        f.mom_y = qmul(f.mass, v);
        f.nrg   = qmul(n, total_energy(rho, u, v, p));
        return f;
    endfunction

    // Shift one accepted cell into the window and queue the update it causes
    task automatic predict_cell_update(input cell_in_t c);
        longint  r [3];
        longint  u [3];
        longint  v [3];
        longint  p [3];
        flux_t   f_right;
        flux_t   f_left;
        longint  nsum;
        longint  ratio;
        longint  rho_n;
        longint  mx_n;
        longint  my_n;
        longint  e_n;
        longint  u_n;
        longint  v_n;
        longint  p_n;
        update_t upd;
        r[2] = c.rho;
        u[2] = c.u;
        v[2] = c.v;
        p[2] = c.p;
        if (held_cells >= 2)
        begin
            for (int k = 0; k < 2; k++)
            begin
                r[k] = win_rho[k];
                u[k] = win_u[k];
                v[k] = win_v[k];
                p[k] = win_p[k];
            end
            f_right = '0;
            f_left  = '0;
            // A face whose normal velocities cancel carries no flux
            nsum = axis_y ? v[1] + v[2] : u[1] + u[2];
            if (nsum > 0)
                f_right = upwind_flux(r[1], u[1], v[1], p[1]);
            else if (nsum < 0)
                f_right = upwind_flux(r[2], u[2], v[2], p[2]);
            nsum = axis_y ? v[0] + v[1] : u[0] + u[1];
            if (nsum > 0)
                f_left = upwind_flux(r[0], u[0], v[0], p[0]);
            else if (nsum < 0)
                f_left = upwind_flux(r[1], u[1], v[1], p[1]);

            ratio = qdiv(longint'(tstep), mid_spacing);
            rho_n = clip(r[1] - qmul(ratio, clip(f_right.mass - f_left.mass)));
            mx_n  = clip(qmul(r[1], u[1]) - qmul(ratio, clip(f_right.mom_x - f_left.mom_x)));
            my_n  = clip(qmul(r[1], v[1]) - qmul(ratio, clip(f_right.mom_y - f_left.mom_y)));
            e_n   = clip(total_energy(r[1], u[1], v[1], p[1])
                         - qmul(ratio, clip(f_right.nrg - f_left.nrg)));
            if (rho_n < 1)
                rho_n = 1;
            u_n = qdiv(mx_n, rho_n);
            v_n = qdiv(my_n, rho_n);
            p_n = qmul(longint'(gamma_m1), clip(e_n - kinetic(rho_n, u_n, v_n)));
            if (p_n < 1)
                p_n = 1;
            upd.rho  = rho_n[TW-1:0];
            upd.u    = u_n[QW-1:0];
            upd.v    = v_n[QW-1:0];
            upd.p    = p_n[TW-1:0];
            upd.last = c.last;
            expected_updates.push_back(upd);
        end
        win_rho[0] = win_rho[1];
        win_u[0]   = win_u[1];
        win_v[0]   = win_v[1];
        win_p[0]   = win_p[1];
        win_rho[1] = r[2];
        win_u[1]   = u[2];
        win_v[1]   = v[2];
        win_p[1]   = p[2];
        mid_spacing = longint'(c.spacing);
        // line_end always empties the window
        if (c.last)
            held_cells = 0;
        else if (held_cells < 2)
            held_cells++;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Call at a falling edge while idle; land one register write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_GAMMA: gamma_m1 = data[GW-1:0];
            REG_TSTEP: tstep    = data;
            REG_AXIS:  axis_y   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [GW-1:0] g, input logic [TW-1:0] ts, input logic ax);
        write_reg(REG_GAMMA, TW'(g));
        write_reg(REG_TSTEP, ts);
        write_reg(REG_AXIS, TW'(ax));
    endtask

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic send_cell(input cell_in_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        density      <= c.rho;
        x_velocity   <= c.u;
        y_velocity   <= c.v;
        pressure     <= c.p;
        cell_spacing <= c.spacing;
        line_end     <= c.last;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_cell_update(c);
        cells_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every expected update is back, then let the
    // back end settle before touching the registers
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic cell_in_t make_cell(input bit wild, input bit last);
        cell_in_t c;
        if (wild)
        begin
            c.rho     = $urandom;
            c.u       = $urandom;
            c.v       = $urandom;
            c.p       = $urandom;
            c.spacing = TW'($urandom_range(1, 31'h7FFF_FFFF));
        end
        else
        begin
            c.rho     = $urandom_range(3000, 10 * 65536);
            c.u       = ($urandom_range(0, 5) == 0) ? 0
                        : int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
            c.v       = ($urandom_range(0, 5) == 0) ? 0
                        : int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
            c.p       = $urandom_range(1, 8 * 65536);
            c.spacing = TW'($urandom_range(8192, 4 * 65536));
        end
        c.last = last;
        return c;
    endfunction

    function automatic cell_in_t cell_of(input int rho, input int u, input int v, input int p,
                                         input int spacing, input bit last);
        cell_in_t c;
        c.rho     = rho;
        c.u       = u;
        c.v       = v;
        c.p       = p;
        c.spacing = spacing[TW-1:0];
        c.last    = last;
        return c;
    endfunction

    // Stream random lines: mostly well-formed, some wild data and short lines
    task automatic send_random_lines(input int n_cells);
        int len;
        int sent;
        bit wild;
        sent = 0;
        while (sent < n_cells)
        begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            wild = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++)
                send_cell(make_cell(wild || ($urandom_range(0, 9) == 0), k == len - 1));
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_updates.size() == 0)
            begin
                report_mismatch("result count", updates_checked + 1, updates_checked);
            end
            else
            begin
                update_t want;
                want = expected_updates.pop_front();
                updates_checked++;
                if (new_density !== want.rho)
                    report_mismatch("new_density", new_density, want.rho);
                if (new_x_velocity !== want.u)
                    report_mismatch("new_x_velocity", new_x_velocity, want.u);
                if (new_y_velocity !== want.v)
                    report_mismatch("new_y_velocity", new_y_velocity, want.v);
                if (new_pressure !== want.p)
                    report_mismatch("new_pressure", new_pressure, want.p);
                if (result_line_end !== want.last)
                    report_mismatch("result_line_end", result_line_end, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Hand-picked lines at reset settings: flow both ways, stagnant faces,
    // field extremes, negative data and short lines
    task automatic test_directed();
        send_cell(cell_of(65536, 65536, 0, 65536, 65536, 1'b0));
        send_cell(cell_of(2 * 65536, 32768, 1000, 2 * 65536, 65536, 1'b0));
        send_cell(cell_of(65536, -32768, -1000, 65536, 65536, 1'b0));
        // Velocities that cancel across both faces of the next middle cell
        send_cell(cell_of(65536, 32768, 0, 65536, 1, 1'b0));
        send_cell(cell_of(3 * 65536, -65536, 0, 65536, 65536, 1'b1));
        // Short lines: lone cell, then two cells
        send_cell(cell_of(65536, 0, 0, 65536, 65536, 1'b1));
        send_cell(cell_of(65536, 1, 1, 65536, 65536, 1'b0));
        send_cell(cell_of(65536, 1, 1, 65536, 65536, 1'b1));
        // Extremes and negative density and pressure
        send_cell(cell_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 1'b0));
        send_cell(cell_of(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          1, 1'b0));
        send_cell(cell_of(-65536, 32'h7FFF_FFFF, 0, -65536, 32'h7FFF_FFFF, 1'b0));
        send_cell(cell_of(0, 0, 0, 0, 65536, 1'b0));
        send_cell(cell_of(1, -1, 1, 1, 1, 1'b0));
        send_cell(cell_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h4000_0000, 1'b1));
        drain_results();
    endtask

    // Extreme register values, y sweep included
    task automatic test_register_extremes();
        set_regs(19'd655, 31'd0, 1'b1);
        send_random_lines(12);
        drain_results();
        set_regs(19'd262144, 31'h7FFF_FFFF, 1'b0);
        send_random_lines(12);
        drain_results();
        set_regs(19'd262144, 31'd65536, 1'b1);
        send_random_lines(12);
        drain_results();
    endtask

    // Random lines under one idling scheme and random registers
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_regs(GW'($urandom_range(655, 262144)), TW'($urandom_range(0, 4 * 65536)),
                 1'($urandom_range(0, 1)));
        send_random_lines(n / 2);
        // Pause the sender mid-run until everything is back
        drain_results();
        send_random_lines(n - n / 2);
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        density      = '0;
        x_velocity   = '0;
        y_velocity   = '0;
        pressure     = '0;
        cell_spacing = '0;
        line_end     = 1'b0;
        out_ready    = 1'b0;
        gamma_m1     = GAMMA_RST;
        tstep        = TSTEP_RST;
        axis_y       = 1'b0;
        win_rho      = '{0, 0};
        win_u        = '{0, 0};
        win_v        = '{0, 0};
        win_p        = '{0, 0};
        mid_spacing  = 0;
        held_cells   = 0;
        error_count    = 0;
        cells_sent     = 0;
        updates_checked = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_register_extremes();
        test_random_phase(0, 0, 110);
        test_random_phase(61, 0, 110);
        test_random_phase(0, 61, 110);
        test_random_phase(12, 12, 110);

        $display("Covered %0d cells, %0d updates checked, over both sweep axes,",
                 cells_sent, updates_checked);
        $display("register extremes, short lines and four handshake pressure phases.");
        if (error_count == 0)
            $display("PASS flic_euler_upwind_flux_stage");
        else
            $display("FAIL flic_euler_upwind_flux_stage");
        $finish;
    end

    // Watchdog: stop the run with a failure if it hangs
    initial
    begin
        #15_000_000;
        $display("Timed out with %0d updates outstanding", expected_updates.size());
        $display("FAIL flic_euler_upwind_flux_stage");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fleuf_pkg.sv
rtl/fleuf_div.sv
rtl/fleuf_front.sv
rtl/fleuf_back.sv
rtl/flic_euler_upwind_flux_stage.sv
test/tb_flic_euler_upwind_flux_stage.sv
